@@ rtl/core/mse_pkg.sv @@
// ---------------------------------------------------------------------------
// mse_pkg
// Opcodes, status codes and shared types of the MIPS-subset execute unit.
// ---------------------------------------------------------------------------
package mse_pkg;

    localparam int unsigned NUM_REGS = 32;
    localparam int unsigned REG_IDX_W = 5;

    localparam logic [5:0] OP_RTYPE = 6'b000000;
    localparam logic [5:0] OP_BGE   = 6'b000001;
    localparam logic [5:0] OP_J     = 6'b000010;
    localparam logic [5:0] OP_ADDI  = 6'b001000;
    localparam logic [5:0] OP_LB    = 6'b100000;
    localparam logic [5:0] OP_LW    = 6'b100011;
    localparam logic [5:0] OP_SW    = 6'b101011;
    localparam logic [5:0] OP_LA    = 6'b101111;

    localparam logic [5:0] FN_ADD = 6'h20;

    localparam logic REQ_EXEC    = 1'b0;
    localparam logic REQ_PRELOAD = 1'b1;

    localparam logic [31:0] PC_STEP      = 32'd4;
    localparam logic [31:0] PC_HIGH_MASK = 32'hF000_0000;

    typedef enum logic [1:0] {
        ST_EXECUTED  = 2'd0,
        ST_HALTED    = 2'd1,
        ST_ILLEGAL   = 2'd2,
        ST_PRELOADED = 2'd3
    } status_t;

    // One data memory access; the address is a full byte address that the
    // memory wraps to its own size.
    typedef struct packed {
        logic        rd;
        logic        wr;
        logic [31:0] addr;
        logic [31:0] data;
    } mem_req_t;

    typedef struct packed {
        status_t                status;
        logic [31:0]            next_pc;
        logic                   stop;
        logic                   reg_wr;
        logic [REG_IDX_W-1:0]   reg_idx;
        logic [31:0]            reg_val;
        logic                   load;
        logic                   load_byte;
        mem_req_t               mem;
    } exec_res_t;

endpackage

@@ rtl/core/mse_req_if.sv @@
// ---------------------------------------------------------------------------
// mse_req_if
// Request channel: execute one instruction word or preload one memory word.
// ---------------------------------------------------------------------------
interface mse_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [31:0] instr_word;
    logic [15:0] load_addr;
    logic [31:0] load_data;

    modport source (
        output valid,
        output req_type,
        output instr_word,
        output load_addr,
        output load_data,
        input  ready
    );

    modport sink (
        input  valid,
        input  req_type,
        input  instr_word,
        input  load_addr,
        input  load_data,
        output ready
    );
endinterface

@@ rtl/core/mse_rsp_if.sv @@
// ---------------------------------------------------------------------------
// mse_rsp_if
// Result channel: status, next program counter and register write report.
// ---------------------------------------------------------------------------
interface mse_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] next_pc;
    logic        reg_written;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;

    modport source (
        output valid,
        output status,
        output next_pc,
        output reg_written,
        output reg_index,
        output reg_value,
        input  ready
    );

    modport sink (
        input  valid,
        input  status,
        input  next_pc,
        input  reg_written,
        input  reg_index,
        input  reg_value,
        output ready
    );
endinterface

@@ rtl/core/mse_regfile.sv @@
// ---------------------------------------------------------------------------
// mse_regfile
// 32 x 32 register file, two registered read ports and one write port.
// Entries read as zero until first written; a write in the same cycle as a
// read of the same entry is passed straight to the read data.
// ---------------------------------------------------------------------------
module mse_regfile (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           rd_en,
    input  logic [mse_pkg::REG_IDX_W-1:0]  rd_a_idx,
    input  logic [mse_pkg::REG_IDX_W-1:0]  rd_b_idx,
    output logic [31:0]                    rd_a_data,
    output logic [31:0]                    rd_b_data,
    input  logic                           wr_en,
    input  logic [mse_pkg::REG_IDX_W-1:0]  wr_idx,
    input  logic [31:0]                    wr_data
);

    logic [31:0]                   rf_mem [mse_pkg::NUM_REGS];
    logic [mse_pkg::NUM_REGS-1:0]  vld_reg;
    logic [31:0]                   a_data_reg;
    logic [31:0]                   b_data_reg;
    logic                          a_ok_reg;
    logic                          b_ok_reg;
    logic                          fwd_a;
    logic                          fwd_b;

    assign fwd_a = wr_en && (wr_idx == rd_a_idx);
    assign fwd_b = wr_en && (wr_idx == rd_b_idx);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rf_mem[wr_idx] <= wr_data;
        end
        if (rd_en)
        begin
            a_data_reg <= fwd_a ? wr_data : rf_mem[rd_a_idx];
            b_data_reg <= fwd_b ? wr_data : rf_mem[rd_b_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            a_ok_reg <= 1'b0;
            b_ok_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_idx] <= 1'b1;
            end
            if (rd_en)
            begin
                a_ok_reg <= fwd_a || vld_reg[rd_a_idx];
                b_ok_reg <= fwd_b || vld_reg[rd_b_idx];
            end
        end
    end

    assign rd_a_data = a_ok_reg ? a_data_reg : '0;
    assign rd_b_data = b_ok_reg ? b_data_reg : '0;

endmodule

@@ rtl/core/mse_dmem.sv @@
// ---------------------------------------------------------------------------
// mse_dmem
// Byte-addressed data memory in four byte lanes, so that an unaligned
// little-endian word is one row access in each lane. Addresses wrap at
// MEM_BYTES, which must be a power of two.
// ---------------------------------------------------------------------------
module mse_dmem #(
    parameter int unsigned MEM_BYTES = 65536
) (
    input  logic              clk,
    input  logic              rst_n,
    input  mse_pkg::mem_req_t req,
    output logic [31:0]       rd_data
);

    localparam int unsigned ADDR_W = $clog2(MEM_BYTES);
    localparam int unsigned ROWS   = MEM_BYTES / 4;
    localparam int unsigned ROW_W  = ADDR_W - 2;

    logic [ADDR_W-1:0] addr;
    logic [1:0]        off;
    logic [ROW_W-1:0]  row0;
    logic [1:0]        off_reg;
    logic [7:0]        lane_q [4];

    assign addr = req.addr[ADDR_W-1:0];
    assign off  = addr[1:0];
    assign row0 = addr[ADDR_W-1:2];

    for (genvar k = 0; k < 4; k++)
    begin : g_lane
        localparam logic [1:0] LANE = 2'(k);

        logic [7:0]       bank_mem [ROWS];
        logic [7:0]       q_reg;
        logic [1:0]       byte_sel;
        logic [ROW_W-1:0] row;
        logic [7:0]       wr_byte;

        // Lanes below the start offset hold the bytes that spill into the
        // next row.
        assign byte_sel = LANE - off;
        assign row      = row0 + ROW_W'(LANE < off);
        assign wr_byte  = 8'(req.data >> {byte_sel, 3'b000});

        always_ff @(posedge clk)
        begin
            if (req.wr)
            begin
                bank_mem[row] <= wr_byte;
            end
            if (req.rd)
            begin
                q_reg <= bank_mem[row];
            end
        end

        assign lane_q[k] = q_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg <= '0;
        end
        else if (req.rd)
        begin
            off_reg <= off;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            rd_data[8*i +: 8] = lane_q[2'(off_reg + 2'(i))];
        end
    end

endmodule

@@ rtl/core/mse_exec.sv @@
// ---------------------------------------------------------------------------
// mse_exec
// Decode and execute of one request: next program counter, register write,
// memory access and status.
// ---------------------------------------------------------------------------
module mse_exec (
    input  logic               req_type,
    input  logic [31:0]        instr,
    input  logic [15:0]        load_addr,
    input  logic [31:0]        load_data,
    input  logic [31:0]        rs_val,
    input  logic [31:0]        rt_val,
    input  logic [31:0]        pc,
    input  logic               stopped,
    output mse_pkg::exec_res_t res
);

    logic [5:0]  op;
    logic [5:0]  funct;
    logic [4:0]  rt_idx;
    logic [4:0]  rd_idx;
    logic [31:0] simm;
    logic [31:0] ea;
    logic [31:0] pc_inc;

    assign op     = instr[31:26];
    assign funct  = instr[5:0];
    assign rt_idx = instr[20:16];
    assign rd_idx = instr[15:11];
    assign simm   = {{16{instr[15]}}, instr[15:0]};
    assign ea     = rs_val + simm;
    assign pc_inc = pc + mse_pkg::PC_STEP;

    always_comb
    begin
        res          = '0;
        res.status   = mse_pkg::ST_EXECUTED;
        res.next_pc  = pc;
        res.mem.addr = ea;
        res.mem.data = rt_val;

        priority if (req_type == mse_pkg::REQ_PRELOAD)
        begin
            res.status   = mse_pkg::ST_PRELOADED;
            res.mem.wr   = 1'b1;
            res.mem.addr = {16'b0, load_addr};
            res.mem.data = load_data;
        end
        else if (stopped)
        begin
            res.status = mse_pkg::ST_HALTED;
        end
        else if (instr == '0)
        begin
            res.status = mse_pkg::ST_HALTED;
            res.stop   = 1'b1;
        end
        else
        begin
            unique case (op)
                mse_pkg::OP_LA:
                begin
                    res.reg_wr  = 1'b1;
                    res.reg_idx = rt_idx;
                    res.reg_val = {16'b0, instr[15:0]};
                    res.next_pc = pc_inc;
                end
                mse_pkg::OP_LB:
                begin
                    res.reg_wr    = 1'b1;
                    res.reg_idx   = rt_idx;
                    res.load      = 1'b1;
                    res.load_byte = 1'b1;
                    res.mem.rd    = 1'b1;
                    res.next_pc   = pc_inc;
                end
                mse_pkg::OP_LW:
                begin
                    res.reg_wr  = 1'b1;
                    res.reg_idx = rt_idx;
                    res.load    = 1'b1;
                    res.mem.rd  = 1'b1;
                    res.next_pc = pc_inc;
                end
                mse_pkg::OP_SW:
                begin
                    res.mem.wr  = 1'b1;
                    res.next_pc = pc_inc;
                end
                mse_pkg::OP_ADDI:
                begin
                    res.reg_wr  = 1'b1;
                    res.reg_idx = rt_idx;
                    res.reg_val = ea;
                    res.next_pc = pc_inc;
                end
                mse_pkg::OP_RTYPE:
                begin
                    if (funct == mse_pkg::FN_ADD)
                    begin
                        res.reg_wr  = 1'b1;
                        res.reg_idx = rd_idx;
                        res.reg_val = rs_val + rt_val;
                        res.next_pc = pc_inc;
                    end
                    else
                    begin
                        res.status = mse_pkg::ST_ILLEGAL;
                        res.stop   = 1'b1;
                    end
                end
                mse_pkg::OP_BGE:
                begin
                    res.next_pc = (rs_val >= rt_val) ? pc_inc + {simm[29:0], 2'b00}
                                                     : pc_inc;
                end
                mse_pkg::OP_J:
                begin
                    res.next_pc = (pc & mse_pkg::PC_HIGH_MASK) | {4'b0, instr[25:0], 2'b00};
                end
                default:
                begin
                    res.status = mse_pkg::ST_ILLEGAL;
                    res.stop   = 1'b1;
                end
            endcase
        end
    end

endmodule

@@ rtl/core/mips_subset_execute_unit.sv @@
// ---------------------------------------------------------------------------
// mips_subset_execute_unit
// Executes MIPS-subset instruction words and memory preloads, one result
// per request.
// ---------------------------------------------------------------------------
// Each request passes the execute and result stages and gives one result.
// Requests that write no register (sw, bge, j, halt, illegal, preload) are
// taken one per cycle; a request that writes a register (la, lb, lw, addi,
// add) holds off the next request until it leaves the execute stage, because
// the next request reads its operands from the register file in the cycle
// the result stage writes it. A full result stage that is not drained stalls
// the input. The data memory is MEM_BYTES bytes (a power of two) and needs
// no clearing after reset; reading a byte that was never written returns an
// undefined value. Writing start_pc reloads the program counter and restarts
// a halted unit; do so only while the unit is idle.
// ---------------------------------------------------------------------------
module mips_subset_execute_unit #(
    parameter int unsigned MEM_BYTES = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    mse_req_if.sink     req,
    mse_rsp_if.source   rsp
);

    // Execute stage
    logic                s1_valid_reg;
    logic                s1_valid_next;
    logic                s1_req_type_reg;
    logic [31:0]         s1_instr_reg;
    logic [15:0]         s1_load_addr_reg;
    logic [31:0]         s1_load_data_reg;
    logic                s1_adv;
    logic [31:0]         rs_val;
    logic [31:0]         rt_val;
    mse_pkg::exec_res_t  ex_res;
    mse_pkg::mem_req_t   mem_req;

    // Architectural state
    logic [31:0]         pc_reg;
    logic [31:0]         pc_next;
    logic                stopped_reg;
    logic                stopped_next;

    // Result stage
    logic                s2_valid_reg;
    logic                s2_valid_next;
    logic                s2_fresh_reg;
    mse_pkg::status_t    s2_status_reg;
    logic [31:0]         s2_next_pc_reg;
    logic                s2_reg_wr_reg;
    logic [4:0]          s2_reg_idx_reg;
    logic [31:0]         s2_reg_val_reg;
    logic                s2_load_reg;
    logic                s2_load_byte_reg;
    logic [31:0]         mem_rd_data;
    logic [31:0]         s2_value;

    logic                accept;
    logic                rf_wr_en;

    assign s1_adv     = s1_valid_reg && (!s2_valid_reg || rsp.ready);
    assign req.ready  = (!s1_valid_reg || s1_adv) && !(s1_valid_reg && ex_res.reg_wr);
    assign accept     = req.valid && req.ready;

    mse_regfile u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (accept),
        .rd_a_idx  (req.instr_word[25:21]),
        .rd_b_idx  (req.instr_word[20:16]),
        .rd_a_data (rs_val),
        .rd_b_data (rt_val),
        .wr_en     (rf_wr_en),
        .wr_idx    (s2_reg_idx_reg),
        .wr_data   (s2_value)
    );

    mse_exec u_exec (
        .req_type  (s1_req_type_reg),
        .instr     (s1_instr_reg),
        .load_addr (s1_load_addr_reg),
        .load_data (s1_load_data_reg),
        .rs_val    (rs_val),
        .rt_val    (rt_val),
        .pc        (pc_reg),
        .stopped   (stopped_reg),
        .res       (ex_res)
    );

    // The memory sees an access only in the cycle the item leaves the
    // execute stage, so the read data stays put while the result waits.
    always_comb
    begin
        mem_req    = ex_res.mem;
        mem_req.rd = ex_res.mem.rd && s1_adv;
        mem_req.wr = ex_res.mem.wr && s1_adv;
    end

    mse_dmem #(
        .MEM_BYTES (MEM_BYTES)
    ) u_dmem (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mem_req),
        .rd_data (mem_rd_data)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        s2_valid_next = s2_valid_reg;
        if (s1_adv)
        begin
            s2_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            s2_valid_next = 1'b0;
        end

        pc_next      = pc_reg;
        stopped_next = stopped_reg;
        if (cfg_wr_en)
        begin
            pc_next      = cfg_wr_data;
            stopped_next = 1'b0;
        end
        else if (s1_adv)
        begin
            pc_next      = ex_res.next_pc;
            stopped_next = stopped_reg || ex_res.stop;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s2_fresh_reg <= 1'b0;
            pc_reg       <= '0;
            stopped_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s2_fresh_reg <= s1_adv;
            pc_reg       <= pc_next;
            stopped_reg  <= stopped_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_type_reg  <= req.req_type;
            s1_instr_reg     <= req.instr_word;
            s1_load_addr_reg <= req.load_addr;
            s1_load_data_reg <= req.load_data;
        end
        if (s1_adv)
        begin
            s2_status_reg    <= ex_res.status;
            s2_next_pc_reg   <= ex_res.next_pc;
            s2_reg_wr_reg    <= ex_res.reg_wr;
            s2_reg_idx_reg   <= ex_res.reg_idx;
            s2_reg_val_reg   <= ex_res.reg_val;
            s2_load_reg      <= ex_res.load;
            s2_load_byte_reg <= ex_res.load_byte;
        end
    end

    always_comb
    begin
        s2_value = s2_reg_val_reg;
        if (s2_load_reg)
        begin
            s2_value = s2_load_byte_reg ? {24'b0, mem_rd_data[7:0]} : mem_rd_data;
        end
    end

    // The register file is written once, in the first cycle of the result
    // stage, whether or not the result is taken then.
    assign rf_wr_en = s2_valid_reg && s2_fresh_reg && s2_reg_wr_reg;

    assign rsp.valid       = s2_valid_reg;
    assign rsp.status      = s2_status_reg;
    assign rsp.next_pc     = s2_next_pc_reg;
    assign rsp.reg_written = s2_reg_wr_reg;
    assign rsp.reg_index   = s2_reg_idx_reg;
    assign rsp.reg_value   = s2_value;

endmodule

@@ test/tb_mips_subset_execute_unit.sv @@
// ---------------------------------------------------------------------------
// tb_mips_subset_execute_unit
// Self-checking regression of the MIPS-subset execute unit. A shadow copy of
// the program counter, register file and data memory predicts every result
// beat. Directed tests cover the field extremes, each operation, address
// wrap, unaligned words and the halt, illegal and restart cases. Random
// program phases follow, each started by a start_pc write, with random
// idling on both channels.
// ---------------------------------------------------------------------------
module tb_mips_subset_execute_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RANDOM_ITEMS = 1600;
    localparam int unsigned QUIET_LIMIT  = 2000;
    localparam logic [5:0]  FN_UNSUPPORTED = 6'h21;

    typedef struct {
        mse_pkg::status_t status;
        logic [31:0]      next_pc;
        logic             reg_written;
        logic [4:0]       reg_index;
        logic [31:0]      reg_value;
    } exec_report_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;

    mse_req_if req_bus();
    mse_rsp_if rsp_bus();

    mips_subset_execute_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_bus),
        .rsp         (rsp_bus)
    );

    // Architectural shadow state.
    logic [31:0] arch_pc;
    logic [31:0] arch_regs [0:mse_pkg::NUM_REGS-1];
    logic        unit_stopped;
    logic [7:0]  mem_bytes [0:65535];
    bit          byte_valid [0:65535];
    logic [15:0] stored_words [$];

    exec_report_t pending_results [$];

    bit          req_gap_on;
    bit          rsp_stall_on;
    int unsigned fail_count;
    int unsigned results_checked;
    int unsigned n_exec;
    int unsigned n_preload;
    int unsigned n_stops;
    int unsigned n_restarts;
    int unsigned quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] enc_i(input logic [5:0] op, input logic [4:0] rs,
                                          input logic [4:0] rt, input logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    function automatic logic [31:0] enc_r(input logic [4:0] rs, input logic [4:0] rt,
                                          input logic [4:0] rd, input logic [5:0] funct);
        logic [4:0] shamt;
        shamt = 5'($urandom);
        return {mse_pkg::OP_RTYPE, rs, rt, rd, shamt, funct};
    endfunction

    function automatic logic [31:0] enc_j(input logic [25:0] target);
        return {mse_pkg::OP_J, target};
    endfunction

    // Half of the picks land in a few registers so that dependent
    // instructions follow each other closely.
    function automatic logic [4:0] pick_reg();
        if ($urandom_range(1) == 0)
            return 5'($urandom_range(3));
        return 5'($urandom_range(31));
    endfunction

    function automatic logic [15:0] pick_imm();
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return 16'h7FFF;
            2: return 16'h8000;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic store_word(input logic [15:0] addr, input logic [31:0] value);
        for (int i = 0; i < 4; i++)
        begin
            mem_bytes[addr + 16'(i)] = value[8*i +: 8];
            byte_valid[addr + 16'(i)] = 1'b1;
        end
        stored_words.push_back(addr);
    endtask

    task automatic predict_exec_result(input logic kind, input logic [31:0] w,
                                       input logic [15:0] addr, input logic [31:0] data,
                                       output exec_report_t r);
        logic [5:0]  op;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [31:0] simm;
        logic [31:0] ea;
        logic [15:0] a;
        logic [31:0] pc;
        op = w[31:26];
        rs = w[25:21];
        rt = w[20:16];
        simm = {{16{w[15]}}, w[15:0]};
        ea = arch_regs[rs] + simm;
        a = ea[15:0];
        pc = arch_pc;
        r.status = mse_pkg::ST_EXECUTED;
        r.reg_written = 1'b0;
        r.reg_index = '0;
        r.reg_value = '0;
        if (kind == mse_pkg::REQ_PRELOAD)
        begin
            store_word(addr, data);
            r.status = mse_pkg::ST_PRELOADED;
        end
        else if (unit_stopped)
        begin
            r.status = mse_pkg::ST_HALTED;
        end
        else if (w == 32'h0)
        begin
            r.status = mse_pkg::ST_HALTED;
            unit_stopped = 1'b1;
            n_stops++;
        end
        else
        begin
            case (op)
                mse_pkg::OP_LA:
                begin
                    r.reg_written = 1'b1;
                    r.reg_index = rt;
                    r.reg_value = {16'h0, w[15:0]};
                    pc += mse_pkg::PC_STEP;
                end
                mse_pkg::OP_LB:
                begin
                    r.reg_written = 1'b1;
                    r.reg_index = rt;
                    r.reg_value = {24'h0, mem_bytes[a]};
                    pc += mse_pkg::PC_STEP;
                end
                mse_pkg::OP_LW:
                begin
                    r.reg_written = 1'b1;
                    r.reg_index = rt;
                    r.reg_value = {mem_bytes[a + 16'd3], mem_bytes[a + 16'd2],
                                   mem_bytes[a + 16'd1], mem_bytes[a]};
                    pc += mse_pkg::PC_STEP;
                end
                mse_pkg::OP_SW:
                begin
                    store_word(a, arch_regs[rt]);
                    pc += mse_pkg::PC_STEP;
                end
                mse_pkg::OP_ADDI:
                begin
                    r.reg_written = 1'b1;
                    r.reg_index = rt;
                    r.reg_value = ea;
                    pc += mse_pkg::PC_STEP;
                end
                mse_pkg::OP_RTYPE:
                begin
                    if (w[5:0] == mse_pkg::FN_ADD)
                    begin
                        r.reg_written = 1'b1;
                        r.reg_index = w[15:11];
                        r.reg_value = arch_regs[rs] + arch_regs[rt];
                        pc += mse_pkg::PC_STEP;
                    end
                    else
                    begin
                        r.status = mse_pkg::ST_ILLEGAL;
                    end
                end
                mse_pkg::OP_BGE:
                begin
                    if (arch_regs[rs] >= arch_regs[rt])
                        pc = pc + mse_pkg::PC_STEP + (simm << 2);
                    else
                        pc += mse_pkg::PC_STEP;
                end
                mse_pkg::OP_J:
                begin
                    pc = (pc & mse_pkg::PC_HIGH_MASK) | {4'h0, w[25:0], 2'b00};
                end
                default:
                begin
                    r.status = mse_pkg::ST_ILLEGAL;
                end
            endcase
            if (r.status == mse_pkg::ST_ILLEGAL)
            begin
                unit_stopped = 1'b1;
                n_stops++;
                r.reg_written = 1'b0;
                r.reg_index = '0;
                r.reg_value = '0;
            end
            else
            begin
                if (r.reg_written)
                    arch_regs[r.reg_index] = r.reg_value;
                arch_pc = pc;
            end
        end
        r.next_pc = arch_pc;
    endtask

    // Sends one request beat and records its prediction once it is taken.
    task automatic send_beat(input logic kind, input logic [31:0] w,
                             input logic [15:0] addr, input logic [31:0] data);
        logic [31:0]  word;
        logic [31:0]  ea;
        logic [15:0]  base;
        logic [4:0]   rs;
        bit           readable;
        exec_report_t predicted;
        word = w;
        rs = w[25:21];
        // A load may only touch bytes that were written; otherwise its
        // offset is bent onto a stored word.
        if (kind == mse_pkg::REQ_EXEC && !unit_stopped
            && (w[31:26] == mse_pkg::OP_LB || w[31:26] == mse_pkg::OP_LW))
        begin
            ea = arch_regs[rs] + {{16{w[15]}}, w[15:0]};
            readable = byte_valid[ea[15:0]];
            if (w[31:26] == mse_pkg::OP_LW)
            begin
                for (int i = 1; i < 4; i++)
                    readable &= byte_valid[ea[15:0] + 16'(i)];
            end
            if (!readable)
            begin
                base = stored_words[$urandom_range(stored_words.size() - 1)];
                if (w[31:26] == mse_pkg::OP_LB)
                    base += 16'($urandom_range(3));
                word[15:0] = base - arch_regs[rs][15:0];
            end
        end
        while (req_gap_on && $urandom_range(99) < 11)
        begin
            req_bus.valid <= 1'b0;
            @(posedge clk);
        end
        req_bus.valid      <= 1'b1;
        req_bus.req_type   <= kind;
        req_bus.instr_word <= word;
        req_bus.load_addr  <= addr;
        req_bus.load_data  <= data;
        do
            @(posedge clk);
        while (!req_bus.ready);
        predict_exec_result(kind, word, addr, data, predicted);
        pending_results.push_back(predicted);
        if (kind == mse_pkg::REQ_PRELOAD)
            n_preload++;
        else
            n_exec++;
    endtask

    task automatic wait_results_drained();
        req_bus.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    task automatic write_start_pc(input logic [31:0] value);
        wait_results_drained();
        repeat (3) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        arch_pc = value;
        unit_stopped = 1'b0;
        n_restarts++;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
            fail_count++;
        end
    endtask

    // Result checker and receiver stall generator.
    always @(posedge clk)
    begin : result_monitor
        exec_report_t want;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            results_checked++;
            if (pending_results.size() == 0)
            begin
                $error("result beat arrived with no pending expectation");
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("status", 32'(want.status), 32'(rsp_bus.status));
                check_field("next_pc", want.next_pc, rsp_bus.next_pc);
                check_field("reg_written", 32'(want.reg_written), 32'(rsp_bus.reg_written));
                check_field("reg_index", 32'(want.reg_index), 32'(rsp_bus.reg_index));
                check_field("reg_value", want.reg_value, rsp_bus.reg_value);
            end
        end
        rsp_bus.ready <= !(rsp_stall_on && $urandom_range(99) < 11);
    end

    always @(posedge clk)
    begin
        if (!rst_n || cfg_wr_en || (req_bus.valid && req_bus.ready)
            || (rsp_bus.valid && rsp_bus.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles + 1 >= QUIET_LIMIT)
        begin
            $display("mips_subset_execute_unit regression: fail");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic test_preload_edges();
        send_beat(mse_pkg::REQ_PRELOAD, $urandom, 16'h0000, 32'h8899_AABB);
        // This word wraps over the top of memory into bytes 0..2.
        send_beat(mse_pkg::REQ_PRELOAD, $urandom, 16'hFFFF, 32'hFFFF_FFFF);
        send_beat(mse_pkg::REQ_PRELOAD, $urandom, 16'h4000, 32'h0000_0000);
    endtask

    task automatic test_alu_ops();
        send_beat(mse_pkg::REQ_EXEC, enc_i(mse_pkg::OP_LA, 5'd31, 5'd0, 16'hFFFF), '0, '0);
        send_beat(mse_pkg::REQ_EXEC, enc_i(mse_pkg::OP_LA, 5'd0, 5'd31, 16'h0000), '0, '0);
        send_beat(mse_pkg::REQ_EXEC, enc_i(mse_pkg::OP_ADDI, 5'd31, 5'd1, 16'h8000), '0, '0);
        send_beat(mse_pkg::REQ_EXEC, enc_i(mse_pkg::OP_ADDI, 5'd1, 5'd2, 16'h7FFF), '0, '0);
        send_beat(mse_pkg::REQ_EXEC, enc_r(5'd2, 5'd0, 5'd3, mse_pkg::FN_ADD), '0, '0);
    endtask

    task automatic test_memory_ops();
        send_beat(mse_pkg::REQ_EXEC, enc_i(mse_pkg::OP_LW, 5'd31, 5'd4, 16'hFFFF), '0, '0);
        send_beat(mse_pkg::REQ_EXEC, enc_i(mse_pkg::OP_LB, 5'd31, 5'd5, 16'h0003), '0, '0);
        send_beat(mse_pkg::REQ_EXEC, enc_i(mse_pkg::OP_SW, 5'd31, 5'd1, 16'h7FFE), '0, '0);
        send_beat(mse_pkg::REQ_EXEC, enc_i(mse_pkg::OP_LW, 5'd31, 5'd6, 16'h7FFE), '0, '0);
        // Negative offset from a large base wraps back to the bottom.
        send_beat(mse_pkg::REQ_EXEC, enc_i(mse_pkg::OP_LB, 5'd1, 5'd7, 16'h8002), '0, '0);
    endtask

    task automatic test_branches();
        send_beat(mse_pkg::REQ_EXEC, enc_i(mse_pkg::OP_BGE, 5'd2, 5'd0, 16'h8000), '0, '0);
        send_beat(mse_pkg::REQ_EXEC, enc_i(mse_pkg::OP_BGE, 5'd0, 5'd2, 16'h0010), '0, '0);
        send_beat(mse_pkg::REQ_EXEC, enc_i(mse_pkg::OP_BGE, 5'd31, 5'd31, 16'h7FFF), '0, '0);
        send_beat(mse_pkg::REQ_EXEC, enc_j(26'h3FF_FFFF), '0, '0);
    endtask

    task automatic test_stop_and_restart();
        write_start_pc(32'hFFFF_FFFC);
        send_beat(mse_pkg::REQ_EXEC, enc_i(mse_pkg::OP_LA, 5'd0, 5'd8, 16'h1234), '0, '0);
        send_beat(mse_pkg::REQ_EXEC, enc_r(5'd8, 5'd8, 5'd9, FN_UNSUPPORTED), '0, '0);
        send_beat(mse_pkg::REQ_EXEC, enc_i(mse_pkg::OP_LA, 5'd0, 5'd10, 16'h5555), '0, '0);
        send_beat(mse_pkg::REQ_PRELOAD, $urandom, 16'h4002, 32'h5A5A_5A5A);
        write_start_pc(32'hFFFF_FFFF);
        send_beat(mse_pkg::REQ_EXEC, 32'hFFFF_FFFF, '0, '0);
        write_start_pc(mse_pkg::PC_HIGH_MASK);
        send_beat(mse_pkg::REQ_EXEC, enc_j(26'h000_0010), '0, '0);
        send_beat(mse_pkg::REQ_EXEC, 32'h0, '0, '0);
    endtask

    // Random programs, each started by a start_pc write and run until its
    // length is used up or shortly after the unit stops.
    task automatic test_random_programs();
        int unsigned counted;
        int unsigned phase_len;
        int unsigned after_stop;
        int unsigned pick;
        logic        kind;
        logic [31:0] word;
        logic [31:0] seed_pc;
        logic [15:0] addr;
        logic [31:0] data;
        logic [5:0]  funct;
        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            case ($urandom_range(7))
                0: seed_pc = 32'h0000_0000;
                1: seed_pc = 32'hFFFF_FFFF;
                2: seed_pc = 32'hFFFF_FFFC;
                3: seed_pc = mse_pkg::PC_HIGH_MASK;
                default: seed_pc = $urandom;
            endcase
            write_start_pc(seed_pc);
            phase_len = $urandom_range(20, 60);
            after_stop = 0;
            for (int i = 0; i < phase_len && after_stop < 3; i++)
            begin
                // One long stretch runs with no idling on either side.
                req_gap_on = !(counted >= 600 && counted < 850);
                rsp_stall_on = req_gap_on;
                if (unit_stopped)
                    after_stop++;
                else
                    counted++;
                kind = mse_pkg::REQ_EXEC;
                word = $urandom;
                addr = 16'($urandom);
                data = $urandom;
                pick = $urandom_range(99);
                if (pick < 2)
                    word = word;
                else if (pick < 3)
                    word = 32'h0;
                else if (pick < 13)
                begin
                    kind = mse_pkg::REQ_PRELOAD;
                    if ($urandom_range(7) == 0)
                        addr = 16'hFFFC + 16'($urandom_range(3));
                end
                else if (pick < 28)
                    word = enc_i(mse_pkg::OP_LA, 5'($urandom), pick_reg(), pick_imm());
                else if (pick < 43)
                    word = enc_i(mse_pkg::OP_ADDI, pick_reg(), pick_reg(), pick_imm());
                else if (pick < 58)
                begin
                    funct = ($urandom_range(29) == 0) ? 6'($urandom) : mse_pkg::FN_ADD;
                    word = enc_r(pick_reg(), pick_reg(), pick_reg(), funct);
                end
                else if (pick < 68)
                    word = enc_i(mse_pkg::OP_LW, pick_reg(), pick_reg(), 16'($urandom));
                else if (pick < 75)
                    word = enc_i(mse_pkg::OP_LB, pick_reg(), pick_reg(), 16'($urandom));
                else if (pick < 84)
                    word = enc_i(mse_pkg::OP_SW, pick_reg(), pick_reg(), pick_imm());
                else if (pick < 93)
                    word = enc_i(mse_pkg::OP_BGE, pick_reg(), pick_reg(), pick_imm());
                else
                    word = enc_j(26'($urandom));
                if ($urandom_range(59) == 0)
                    wait_results_drained();
                send_beat(kind, word, addr, data);
            end
        end
        req_gap_on = 1'b1;
        rsp_stall_on = 1'b1;
    endtask

    initial
    begin
        rst_n              <= 1'b0;
        cfg_wr_en          <= 1'b0;
        cfg_wr_data        <= '0;
        req_bus.valid      <= 1'b0;
        req_bus.req_type   <= mse_pkg::REQ_EXEC;
        req_bus.instr_word <= '0;
        req_bus.load_addr  <= '0;
        req_bus.load_data  <= '0;
        arch_pc = 32'h0;
        unit_stopped = 1'b0;
        for (int i = 0; i < mse_pkg::NUM_REGS; i++)
            arch_regs[i] = 32'h0;
        req_gap_on = 1'b1;
        rsp_stall_on = 1'b1;
        fail_count = 0;
        results_checked = 0;
        n_exec = 0;
        n_preload = 0;
        n_stops = 0;
        n_restarts = 0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_preload_edges();
        test_alu_ops();
        test_memory_ops();
        test_branches();
        test_stop_and_restart();
        test_random_programs();

        wait_results_drained();
        repeat (8) @(posedge clk);
        $display("Ran %0d instruction beats and %0d preloads over %0d start_pc writes.",
                 n_exec, n_preload, n_restarts);
        $display("The unit stopped %0d times; %0d result beats were compared.",
                 n_stops, results_checked);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("mips_subset_execute_unit regression: pass");
        else
            $display("mips_subset_execute_unit regression: fail");
        $finish;
    end

endmodule
